// ----- hdl/edcu_pkg.sv -----
// Shared types, codes and calendar helpers for the epoch day calendar unit.
package edcu_pkg;

   localparam logic [11:0] FIRST_YEAR = 12'd1970;

   // 1970 residues mod 4, 100 and 400
   localparam logic [1:0] FIRST_R4   = 2'd2;
   localparam logic [6:0] FIRST_R100 = 7'd70;
   localparam logic [8:0] FIRST_R400 = 9'd370;

   // request codes
   localparam logic [2:0] REQ_SET        = 3'd0;
   localparam logic [2:0] REQ_ADD_DAYS   = 3'd1;
   localparam logic [2:0] REQ_ADD_MONTHS = 3'd2;
   localparam logic [2:0] REQ_ADD_YEARS  = 3'd3;
   localparam logic [2:0] REQ_WORKDAY    = 3'd4;

   // error codes
   localparam logic [2:0] ERR_OK    = 3'd0;
   localparam logic [2:0] ERR_YEAR  = 3'd1;
   localparam logic [2:0] ERR_MONTH = 3'd2;
   localparam logic [2:0] ERR_DAY   = 3'd3;
   localparam logic [2:0] ERR_EPOCH = 3'd4;
   localparam logic [2:0] ERR_LIMIT = 3'd5;

   // weekdays, Monday is 0
   localparam logic [2:0] WD_THU = 3'd3;
   localparam logic [2:0] WD_FRI = 3'd4;
   localparam logic [2:0] WD_SAT = 3'd5;
   localparam logic [2:0] WD_SUN = 3'd6;

   localparam logic [3:0] MON_JAN = 4'd1;
   localparam logic [3:0] MON_FEB = 4'd2;
   localparam logic [3:0] MON_DEC = 4'd12;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SPLIT_Y,
      CMD_SPLIT_M,
      CMD_SPLIT_END,
      CMD_DISPATCH,
      CMD_MSTEP,
      CMD_MONTH_END,
      CMD_JOIN_INIT,
      CMD_JOIN_Y,
      CMD_JOIN_M,
      CMD_JOIN_END,
      CMD_COMMIT,
      CMD_OUT
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SPLIT_Y,
      ST_SPLIT_M,
      ST_SPLIT_END,
      ST_DISPATCH,
      ST_ROUTE,
      ST_MSTEP,
      ST_MONTH_END,
      ST_JOIN_INIT,
      ST_JOIN_Y,
      ST_JOIN_M,
      ST_JOIN_END,
      ST_COMMIT,
      ST_FSPLIT_Y,
      ST_FSPLIT_M,
      ST_FSPLIT_END,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       split_y_more;
      logic       split_m_more;
      logic       mstep_more;
      logic       join_y_more;
      logic       join_m_more;
      logic       err_set;
      logic       out_busy;
      logic [2:0] req_type;
   } status_type;

   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
      logic [4:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] year_len(input logic leap);
      return leap ? 9'd366 : 9'd365;
   endfunction

endpackage

// ----- hdl/edcu_ctrl.sv -----
// Sequencer for the calendar unit: split, op, join if any, commit, split again, output.
module edcu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  edcu_pkg::status_type  status,
   output edcu_pkg::cmd_type     cmd
);

   edcu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edcu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != edcu_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = edcu_pkg::CMD_NONE;
      unique case (state_ff)
         edcu_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd      = edcu_pkg::CMD_LOAD;
               state_in = edcu_pkg::ST_SPLIT_Y;
            end
         end
         edcu_pkg::ST_SPLIT_Y: begin
            // datapath keeps day of year once the year walk stops
            cmd = edcu_pkg::CMD_SPLIT_Y;
            if (!status.split_y_more) state_in = edcu_pkg::ST_SPLIT_M;
         end
         edcu_pkg::ST_SPLIT_M: begin
            cmd = edcu_pkg::CMD_SPLIT_M;
            if (!status.split_m_more) state_in = edcu_pkg::ST_SPLIT_END;
         end
         edcu_pkg::ST_SPLIT_END: begin
            cmd      = edcu_pkg::CMD_SPLIT_END;
            state_in = edcu_pkg::ST_DISPATCH;
         end
         edcu_pkg::ST_DISPATCH: begin
            cmd      = edcu_pkg::CMD_DISPATCH;
            state_in = edcu_pkg::ST_ROUTE;
         end
         edcu_pkg::ST_ROUTE: begin
            if (status.err_set) begin
               state_in = edcu_pkg::ST_COMMIT;
            end else begin
               case (status.req_type)
                  edcu_pkg::REQ_SET, edcu_pkg::REQ_ADD_YEARS:
                     state_in = edcu_pkg::ST_JOIN_INIT;
                  edcu_pkg::REQ_ADD_MONTHS:
                     state_in = edcu_pkg::ST_MSTEP;
                  default:
                     state_in = edcu_pkg::ST_COMMIT;
               endcase
            end
         end
         edcu_pkg::ST_MSTEP: begin
            if (status.mstep_more) begin
               cmd = edcu_pkg::CMD_MSTEP;
            end else if (status.err_set) begin
               state_in = edcu_pkg::ST_COMMIT;
            end else begin
               state_in = edcu_pkg::ST_MONTH_END;
            end
         end
         edcu_pkg::ST_MONTH_END: begin
            cmd      = edcu_pkg::CMD_MONTH_END;
            state_in = edcu_pkg::ST_JOIN_INIT;
         end
         edcu_pkg::ST_JOIN_INIT: begin
            cmd      = edcu_pkg::CMD_JOIN_INIT;
            state_in = edcu_pkg::ST_JOIN_Y;
         end
         edcu_pkg::ST_JOIN_Y: begin
            if (status.join_y_more) cmd = edcu_pkg::CMD_JOIN_Y;
            else                    state_in = edcu_pkg::ST_JOIN_M;
         end
         edcu_pkg::ST_JOIN_M: begin
            if (status.join_m_more) cmd = edcu_pkg::CMD_JOIN_M;
            else                    state_in = edcu_pkg::ST_JOIN_END;
         end
         edcu_pkg::ST_JOIN_END: begin
            cmd      = edcu_pkg::CMD_JOIN_END;
            state_in = edcu_pkg::ST_COMMIT;
         end
         edcu_pkg::ST_COMMIT: begin
            cmd      = edcu_pkg::CMD_COMMIT;
            state_in = edcu_pkg::ST_FSPLIT_Y;
         end
         edcu_pkg::ST_FSPLIT_Y: begin
            cmd = edcu_pkg::CMD_SPLIT_Y;
            if (!status.split_y_more) state_in = edcu_pkg::ST_FSPLIT_M;
         end
         edcu_pkg::ST_FSPLIT_M: begin
            cmd = edcu_pkg::CMD_SPLIT_M;
            if (!status.split_m_more) state_in = edcu_pkg::ST_FSPLIT_END;
         end
         edcu_pkg::ST_FSPLIT_END: begin
            cmd      = edcu_pkg::CMD_SPLIT_END;
            state_in = edcu_pkg::ST_OUT;
         end
         edcu_pkg::ST_OUT: begin
            if (!status.out_busy) begin
               cmd      = edcu_pkg::CMD_OUT;
               state_in = edcu_pkg::ST_IDLE;
            end
         end
         default: state_in = edcu_pkg::ST_IDLE;
      endcase
   end

endmodule

// ----- hdl/edcu_dp.sv -----
// Datapath for the calendar unit: year cursor, day accumulator, date and result registers.
module edcu_dp #(
   parameter int YEARS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  edcu_pkg::cmd_type     cmd,
   output edcu_pkg::status_type  status,
   input  logic [2:0]            req_type,
   input  logic [11:0]           req_year_in,
   input  logic [3:0]            req_month_in,
   input  logic [4:0]            req_day_in,
   input  logic signed [17:0]    req_amount,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [16:0]           rsp_day_count,
   output logic [11:0]           rsp_year_out,
   output logic [3:0]            rsp_month_out,
   output logic [4:0]            rsp_day_out,
   output logic [2:0]            rsp_weekday,
   output logic [5:0]            rsp_week_number,
   output logic                  rsp_leap_flag,
   output logic [2:0]            rsp_error_code
);

   localparam logic [11:0] LastYear = 12'(1969 + YEARS);
   localparam int LastPlus = 1969 + YEARS;
   localparam int DayLimitInt = YEARS * 365 + LastPlus / 4 - LastPlus / 100 + LastPlus / 400
                                - (1969 / 4 - 1969 / 100 + 1969 / 400);
   localparam logic signed [19:0] DayLimit  = 20'(DayLimitInt);
   localparam logic signed [19:0] MonthSpan = 20'(12 * YEARS);
   localparam int StepW = $clog2(12 * YEARS + 1);

   // request
   logic [2:0]          typ_ff, typ_in;
   logic [11:0]         yin_ff, yin_in;
   logic [3:0]          min_ff, min_in;
   logic [4:0]          din_ff, din_in;
   logic signed [17:0]  amt_ff, amt_in;
   // stored date and work registers
   logic [16:0]         stored_ff, stored_in;
   logic [16:0]         t_ff, t_in;
   logic [16:0]         nt_ff, nt_in;
   logic [11:0]         yc_ff, yc_in;
   logic [1:0]          r4_ff, r4_in;
   logic [6:0]          r100_ff, r100_in;
   logic [8:0]          r400_ff, r400_in;
   logic [3:0]          mm_ff, mm_in;
   logic [2:0]          wd1_ff, wd1_in;
   logic [8:0]          doy_ff, doy_in;
   logic [11:0]         cy_ff, cy_in;
   logic [3:0]          cm_ff, cm_in;
   logic [4:0]          cd_ff, cd_in;
   logic [2:0]          cwd_ff, cwd_in;
   logic [5:0]          cweek_ff, cweek_in;
   logic                cleap_ff, cleap_in;
   logic [2:0]          err_ff, err_in;
   logic [11:0]         jy_ff, jy_in;
   logic [3:0]          jm_ff, jm_in;
   logic [4:0]          jd_ff, jd_in;
   logic [StepW-1:0]    steps_ff, steps_in;
   logic                fwd_ff, fwd_in;
   // result register
   logic                ov_ff, ov_in;
   logic [16:0]         o_cnt_ff, o_cnt_in;
   logic [11:0]         o_y_ff, o_y_in;
   logic [3:0]          o_m_ff, o_m_in;
   logic [4:0]          o_d_ff, o_d_in;
   logic [2:0]          o_wd_ff, o_wd_in;
   logic [5:0]          o_wk_ff, o_wk_in;
   logic                o_lp_ff, o_lp_in;
   logic [2:0]          o_err_ff, o_err_in;

   // year cursor with residues, so leap years need no divider
   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen_cur, mlen_next, mlen_prev;
   logic        split_y_more, split_m_more;
   logic [6:0]  r100_up, r100_dn;
   logic [8:0]  r400_up, r400_dn;

   assign leap      = (r4_ff == 2'd0) && ((r100_ff != 7'd0) || (r400_ff == 9'd0));
   assign ylen      = edcu_pkg::year_len(leap);
   assign mlen_cur  = edcu_pkg::month_len(leap, mm_ff);
   assign mlen_next = edcu_pkg::month_len(leap, mm_ff + 4'd1);
   assign mlen_prev = edcu_pkg::month_len(leap, mm_ff - 4'd1);
   assign r100_up   = (r100_ff == 7'd99)  ? 7'd0 : r100_ff + 7'd1;
   assign r100_dn   = (r100_ff == 7'd0)   ? 7'd99 : r100_ff - 7'd1;
   assign r400_up   = (r400_ff == 9'd399) ? 9'd0 : r400_ff + 9'd1;
   assign r400_dn   = (r400_ff == 9'd0)   ? 9'd399 : r400_ff - 9'd1;

   assign split_y_more = (yc_ff < LastYear) && (t_ff >= {8'd0, ylen});
   assign split_m_more = (mm_ff < edcu_pkg::MON_DEC) && (t_ff >= {12'd0, mlen_cur});

   // week and weekday from day of year; /7 by reciprocal 293/2048, exact below 372
   logic [2:0]  s_off;
   logic [8:0]  wk_x;
   logic [17:0] wk_prod, dy_prod;
   logic [5:0]  dy_q;
   logic [8:0]  dy_r9;
   logic [3:0]  wd_sum;

   assign s_off   = (wd1_ff == edcu_pkg::WD_SUN) ? 3'd0 : wd1_ff + 3'd1;
   assign wk_x    = doy_ff + {6'd0, s_off};
   assign wk_prod = {9'd0, wk_x} * 18'd293;
   assign dy_prod = {9'd0, doy_ff} * 18'd293;
   assign dy_q    = dy_prod[16:11];
   assign dy_r9   = doy_ff - ({3'd0, dy_q} * 9'd7);
   assign wd_sum  = {1'b0, wd1_ff} + {1'b0, dy_r9[2:0]};

   // dispatch arithmetic
   logic signed [19:0] day_sum, year_sum, amt_w;
   logic [17:0]        amt_mag;
   logic [16:0]        work_sum;

   assign amt_w    = 20'(amt_ff);
   assign day_sum  = $signed({3'd0, stored_ff}) + amt_w;
   assign year_sum = $signed({8'd0, cy_ff}) + amt_w;
   assign amt_mag  = amt_ff[17] ? 18'(-amt_ff) : amt_ff;
   assign work_sum = stored_ff + ((cwd_ff == edcu_pkg::WD_FRI) ? 17'd3 :
                                  (cwd_ff == edcu_pkg::WD_SAT) ? 17'd2 : 17'd1);

   always_comb begin
      typ_in = typ_ff; yin_in = yin_ff; min_in = min_ff; din_in = din_ff; amt_in = amt_ff;
      stored_in = stored_ff; t_in = t_ff; nt_in = nt_ff;
      yc_in = yc_ff; r4_in = r4_ff; r100_in = r100_ff; r400_in = r400_ff;
      mm_in = mm_ff; wd1_in = wd1_ff; doy_in = doy_ff;
      cy_in = cy_ff; cm_in = cm_ff; cd_in = cd_ff; cwd_in = cwd_ff;
      cweek_in = cweek_ff; cleap_in = cleap_ff;
      err_in = err_ff; jy_in = jy_ff; jm_in = jm_ff; jd_in = jd_ff;
      steps_in = steps_ff; fwd_in = fwd_ff;
      ov_in = ov_ff && rsp_stall;
      o_cnt_in = o_cnt_ff; o_y_in = o_y_ff; o_m_in = o_m_ff; o_d_in = o_d_ff;
      o_wd_in = o_wd_ff; o_wk_in = o_wk_ff; o_lp_in = o_lp_ff; o_err_in = o_err_ff;

      unique case (cmd)
         edcu_pkg::CMD_NONE: begin
         end
         edcu_pkg::CMD_LOAD: begin
            typ_in = req_type; yin_in = req_year_in; min_in = req_month_in;
            din_in = req_day_in; amt_in = req_amount;
            t_in = stored_ff; nt_in = stored_ff; err_in = edcu_pkg::ERR_OK;
            yc_in = edcu_pkg::FIRST_YEAR; r4_in = edcu_pkg::FIRST_R4;
            r100_in = edcu_pkg::FIRST_R100; r400_in = edcu_pkg::FIRST_R400;
            mm_in = edcu_pkg::MON_JAN; wd1_in = edcu_pkg::WD_THU;
         end
         edcu_pkg::CMD_SPLIT_Y: begin
            if (split_y_more) begin
               t_in = t_ff - {8'd0, ylen};
               yc_in = yc_ff + 12'd1; r4_in = r4_ff + 2'd1;
               r100_in = r100_up; r400_in = r400_up;
               // 365 mod 7 is 1, 366 mod 7 is 2
               if ({1'b0, wd1_ff} + (leap ? 4'd2 : 4'd1) >= 4'd7)
                  wd1_in = 3'({1'b0, wd1_ff} + (leap ? 4'd2 : 4'd1) - 4'd7);
               else
                  wd1_in = wd1_ff + (leap ? 3'd2 : 3'd1);
            end else begin
               doy_in = t_ff[8:0];
            end
         end
         edcu_pkg::CMD_SPLIT_M: begin
            if (split_m_more) begin
               t_in  = t_ff - {12'd0, mlen_cur};
               mm_in = mm_ff + 4'd1;
            end
         end
         edcu_pkg::CMD_SPLIT_END: begin
            cy_in = yc_ff; cm_in = mm_ff; cd_in = t_ff[4:0] + 5'd1;
            cleap_in = leap;
            cweek_in = wk_prod[16:11] + 6'd1;
            cwd_in   = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
         end
         edcu_pkg::CMD_DISPATCH: begin
            case (typ_ff)
               edcu_pkg::REQ_SET: begin
                  if (yin_ff < edcu_pkg::FIRST_YEAR)                   err_in = edcu_pkg::ERR_YEAR;
                  else if (yin_ff > LastYear)                          err_in = edcu_pkg::ERR_LIMIT;
                  else if (min_ff < edcu_pkg::MON_JAN || min_ff > edcu_pkg::MON_DEC)
                     err_in = edcu_pkg::ERR_MONTH;
                  jy_in = yin_ff; jm_in = min_ff; jd_in = din_ff;
               end
               edcu_pkg::REQ_ADD_DAYS: begin
                  if (day_sum < 0)                 err_in = edcu_pkg::ERR_EPOCH;
                  else if (day_sum >= DayLimit)    err_in = edcu_pkg::ERR_LIMIT;
                  else                             nt_in  = day_sum[16:0];
               end
               edcu_pkg::REQ_ADD_MONTHS: begin
                  if (amt_w > MonthSpan)           err_in = edcu_pkg::ERR_LIMIT;
                  else if (amt_w < -MonthSpan)     err_in = edcu_pkg::ERR_EPOCH;
                  steps_in = amt_mag[StepW-1:0];
                  fwd_in   = !amt_ff[17];
                  jd_in    = cd_ff;
               end
               edcu_pkg::REQ_ADD_YEARS: begin
                  if (year_sum < $signed({8'd0, edcu_pkg::FIRST_YEAR}))
                     err_in = edcu_pkg::ERR_EPOCH;
                  else if (year_sum > $signed({8'd0, LastYear}))
                     err_in = edcu_pkg::ERR_LIMIT;
                  jy_in = year_sum[11:0]; jm_in = cm_ff;
                  // Feb 29 lands on Feb 28 whenever the year moves
                  jd_in = (amt_ff != 18'sd0 && cm_ff == edcu_pkg::MON_FEB && cd_ff == 5'd29)
                          ? 5'd28 : cd_ff;
               end
               edcu_pkg::REQ_WORKDAY: begin
                  if ($signed({3'd0, work_sum}) >= DayLimit) err_in = edcu_pkg::ERR_LIMIT;
                  else                                        nt_in  = work_sum;
               end
               default: begin
               end
            endcase
         end
         edcu_pkg::CMD_MSTEP: begin
            // wraps land in Jan or Dec, which never clamp, so the cursor leap is right
            steps_in = steps_ff - StepW'(1);
            if (fwd_ff) begin
               if (mm_ff == edcu_pkg::MON_DEC) begin
                  if (yc_ff == LastYear) begin
                     err_in = edcu_pkg::ERR_LIMIT;
                  end else begin
                     mm_in = edcu_pkg::MON_JAN;
                     yc_in = yc_ff + 12'd1; r4_in = r4_ff + 2'd1;
                     r100_in = r100_up; r400_in = r400_up;
                  end
               end else begin
                  mm_in = mm_ff + 4'd1;
                  if (jd_ff > mlen_next) jd_in = mlen_next;
               end
            end else begin
               if (mm_ff == edcu_pkg::MON_JAN) begin
                  if (yc_ff == edcu_pkg::FIRST_YEAR) begin
                     err_in = edcu_pkg::ERR_EPOCH;
                  end else begin
                     mm_in = edcu_pkg::MON_DEC;
                     yc_in = yc_ff - 12'd1; r4_in = r4_ff - 2'd1;
                     r100_in = r100_dn; r400_in = r400_dn;
                  end
               end else begin
                  mm_in = mm_ff - 4'd1;
                  if (jd_ff > mlen_prev) jd_in = mlen_prev;
               end
            end
         end
         edcu_pkg::CMD_MONTH_END: begin
            jy_in = yc_ff; jm_in = mm_ff;
         end
         edcu_pkg::CMD_JOIN_INIT: begin
            t_in = 17'd0;
            yc_in = edcu_pkg::FIRST_YEAR; r4_in = edcu_pkg::FIRST_R4;
            r100_in = edcu_pkg::FIRST_R100; r400_in = edcu_pkg::FIRST_R400;
            mm_in = edcu_pkg::MON_JAN;
         end
         edcu_pkg::CMD_JOIN_Y: begin
            t_in = t_ff + {8'd0, ylen};
            yc_in = yc_ff + 12'd1; r4_in = r4_ff + 2'd1;
            r100_in = r100_up; r400_in = r400_up;
         end
         edcu_pkg::CMD_JOIN_M: begin
            t_in  = t_ff + {12'd0, mlen_cur};
            mm_in = mm_ff + 4'd1;
         end
         edcu_pkg::CMD_JOIN_END: begin
            if (typ_ff == edcu_pkg::REQ_SET &&
                (jd_ff == 5'd0 || jd_ff > edcu_pkg::month_len(leap, jm_ff)))
               err_in = edcu_pkg::ERR_DAY;
            nt_in = t_ff + {12'd0, jd_ff} - 17'd1;
         end
         edcu_pkg::CMD_COMMIT: begin
            if (err_ff == edcu_pkg::ERR_OK) begin
               stored_in = nt_ff;
               t_in      = nt_ff;
            end else begin
               t_in      = stored_ff;
            end
            yc_in = edcu_pkg::FIRST_YEAR; r4_in = edcu_pkg::FIRST_R4;
            r100_in = edcu_pkg::FIRST_R100; r400_in = edcu_pkg::FIRST_R400;
            mm_in = edcu_pkg::MON_JAN; wd1_in = edcu_pkg::WD_THU;
         end
         edcu_pkg::CMD_OUT: begin
            ov_in = 1'b1;
            o_cnt_in = stored_ff; o_y_in = cy_ff; o_m_in = cm_ff; o_d_in = cd_ff;
            o_wd_in = cwd_ff; o_wk_in = cweek_ff; o_lp_in = cleap_ff; o_err_in = err_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= 17'd0;
         ov_ff     <= 1'b0;
      end else begin
         stored_ff <= stored_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      typ_ff <= typ_in; yin_ff <= yin_in; min_ff <= min_in; din_ff <= din_in; amt_ff <= amt_in;
      t_ff <= t_in; nt_ff <= nt_in;
      yc_ff <= yc_in; r4_ff <= r4_in; r100_ff <= r100_in; r400_ff <= r400_in;
      mm_ff <= mm_in; wd1_ff <= wd1_in; doy_ff <= doy_in;
      cy_ff <= cy_in; cm_ff <= cm_in; cd_ff <= cd_in; cwd_ff <= cwd_in;
      cweek_ff <= cweek_in; cleap_ff <= cleap_in;
      err_ff <= err_in; jy_ff <= jy_in; jm_ff <= jm_in; jd_ff <= jd_in;
      steps_ff <= steps_in; fwd_ff <= fwd_in;
      o_cnt_ff <= o_cnt_in; o_y_ff <= o_y_in; o_m_ff <= o_m_in; o_d_ff <= o_d_in;
      o_wd_ff <= o_wd_in; o_wk_ff <= o_wk_in; o_lp_ff <= o_lp_in; o_err_ff <= o_err_in;
   end

   assign status.split_y_more = split_y_more;
   assign status.split_m_more = split_m_more;
   assign status.mstep_more   = (steps_ff != '0) && (err_ff == edcu_pkg::ERR_OK);
   assign status.join_y_more  = (yc_ff != jy_ff);
   assign status.join_m_more  = (mm_ff != jm_ff);
   assign status.err_set      = (err_ff != edcu_pkg::ERR_OK);
   assign status.out_busy     = ov_ff && rsp_stall;
   assign status.req_type     = typ_ff;

   assign rsp_valid       = ov_ff;
   assign rsp_day_count   = o_cnt_ff;
   assign rsp_year_out    = o_y_ff;
   assign rsp_month_out   = o_m_ff;
   assign rsp_day_out     = o_d_ff;
   assign rsp_weekday     = o_wd_ff;
   assign rsp_week_number = o_wk_ff;
   assign rsp_leap_flag   = o_lp_ff;
   assign rsp_error_code  = o_err_ff;

endmodule

// ----- hdl/epoch_day_calendar_unit.sv -----
// Top level of the epoch day calendar unit: sequencer plus datapath.
//
// Holds one date as days since 1 Jan 1970 (a Thursday). Each request item on
// req_* sets the date or moves it by days, months or years, or to the next
// workday; each one returns exactly one result item on rsp_* with the stored
// count, year, month, day, weekday, Sunday-first week, leap flag and error.
// A failed request leaves the stored date as it was.
// Both channels: an item moves on a clock edge with valid high and stall low.
// req_stall is high from acceptance until the result is loaded, so one item
// is in work at a time. Every request passes through two date splits, one
// before and one after the commit; each walks Y years past 1970 (up to
// YEARS-1) and M months into the year (up to 11). Set and add-years add a
// join walk for the target date; add-months adds S single-month steps
// (up to 12*YEARS) ahead of its join walk. Add-days, next workday, unused
// types and a request that fails its dispatch checks skip the join walk.
// The result sits in an output register; if rsp_stall holds it, the next
// request is still accepted and processed, and waits only at the final load.
// Reset (synchronous, active high) sets the date to 1 Jan 1970 and empties
// the output register.
module epoch_day_calendar_unit #(
   parameter int YEARS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic [11:0]        req_year_in,
   input  logic [3:0]         req_month_in,
   input  logic [4:0]         req_day_in,
   input  logic signed [17:0] req_amount,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [16:0]        rsp_day_count,
   output logic [11:0]        rsp_year_out,
   output logic [3:0]         rsp_month_out,
   output logic [4:0]         rsp_day_out,
   output logic [2:0]         rsp_weekday,
   output logic [5:0]         rsp_week_number,
   output logic               rsp_leap_flag,
   output logic [2:0]         rsp_error_code
);

   edcu_pkg::cmd_type    cmd;
   edcu_pkg::status_type status;

   edcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   edcu_dp #(
      .YEARS (YEARS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_type),
      .req_year_in     (req_year_in),
      .req_month_in    (req_month_in),
      .req_day_in      (req_day_in),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_day_count   (rsp_day_count),
      .rsp_year_out    (rsp_year_out),
      .rsp_month_out   (rsp_month_out),
      .rsp_day_out     (rsp_day_out),
      .rsp_weekday     (rsp_weekday),
      .rsp_week_number (rsp_week_number),
      .rsp_leap_flag   (rsp_leap_flag),
      .rsp_error_code  (rsp_error_code)
   );

endmodule
